FILE: sv/edsc_pkg.sv
`default_nettype none

package edsc_pkg;

    localparam int MAX_LEN_DEF = 128;
    localparam int SYM_W       = 8;
    localparam int ACT_W       = 2;
    localparam int DIST_W      = 9;
    localparam int DIST_MAX    = 511;
    localparam int SUB_COST    = 2;

    typedef enum logic [ACT_W-1:0] {
        ACT_START  = 2'd0,
        ACT_FIRST  = 2'd1,
        ACT_SECOND = 2'd2,
        ACT_REPORT = 2'd3
    } action_t;

    // control bits of a token moving down the cell chain
    typedef struct packed {
        logic valid;
        logic report;
        logic ovf;
    } tok_ctl_t;

endpackage

`default_nettype wire

FILE: sv/edsc_cell.sv
`default_nettype none

module edsc_cell #(
    parameter int MAX_LEN = edsc_pkg::MAX_LEN_DEF,
    parameter int IDX     = 0,
    parameter int IW      = $clog2(MAX_LEN),
    parameter int LW      = $clog2(MAX_LEN + 1),
    parameter int VW      = $clog2(2 * MAX_LEN + 3)
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      adv,
    input  wire logic [LW-1:0]             fl,
    input  wire logic                      wr_en,
    input  wire logic [IW-1:0]             wr_idx,
    input  wire logic [edsc_pkg::SYM_W-1:0] wr_sym,
    input  wire edsc_pkg::tok_ctl_t        in_ctl,
    input  wire logic [edsc_pkg::SYM_W-1:0] in_sym,
    input  wire logic [VW-1:0]             in_newv,
    input  wire logic [VW-1:0]             in_oldv,
    output edsc_pkg::tok_ctl_t             out_ctl,
    output logic [edsc_pkg::SYM_W-1:0]     out_sym,
    output logic [VW-1:0]                  out_newv,
    output logic [VW-1:0]                  out_oldv
);

    edsc_pkg::tok_ctl_t              ctl_reg;
    logic [edsc_pkg::SYM_W-1:0]      chr_reg;
    logic [VW-1:0]                   val_reg;
    logic [edsc_pkg::SYM_W-1:0]      sym_reg;
    logic [VW-1:0]                   newv_reg;
    logic [VW-1:0]                   oldv_reg;

    logic                            hit;
    logic                            tap;
    logic [VW-1:0]                   cost_up;
    logic [VW-1:0]                   cost_left;
    logic [VW-1:0]                   cost_diag;
    logic [VW-1:0]                   best;

    assign hit = wr_en && (wr_idx == IW'(IDX));
    // this cell holds the row entry at the first string's length
    assign tap = in_ctl.report && (fl == LW'(IDX + 1));

    always_comb
    begin
        cost_up   = val_reg + VW'(1);
        cost_left = in_newv + VW'(1);
        cost_diag = in_oldv + ((chr_reg == in_sym) ? VW'(0) : VW'(edsc_pkg::SUB_COST));
        best      = (cost_up < cost_left) ? cost_up : cost_left;
        if (cost_diag < best)
        begin
            best = cost_diag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (adv)
        begin
            ctl_reg <= in_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hit)
        begin
            chr_reg <= wr_sym;
            val_reg <= VW'(IDX + 1);
        end
        else if (adv && in_ctl.valid && !in_ctl.report)
        begin
            val_reg <= best;
        end

        if (adv)
        begin
            sym_reg  <= in_sym;
            oldv_reg <= val_reg;
            if (in_ctl.report)
            begin
                newv_reg <= tap ? val_reg : in_newv;
            end
            else
            begin
                newv_reg <= best;
            end
        end
    end

    assign out_ctl  = ctl_reg;
    assign out_sym  = sym_reg;
    assign out_newv = newv_reg;
    assign out_oldv = oldv_reg;

endmodule

`default_nettype wire

FILE: sv/edit_distance_sub_cost_two.sv
// Edit distance engine, substitution cost two (insert/delete 1, mismatch 2).
// Input stream: s_tuser[1:0] = action, s_tdata[7:0] = symbol.
//   action 0 starts a pair, 1 appends to the first string, 2 appends to the
//   second string, 3 requests the distance. Only action 3 yields a result.
// Output stream: m_tdata[8:0] = distance (saturated at 511), m_tuser[0] =
//   overflow (a character was dropped beyond MAX_LEN).
// The first string sits in a row of MAX_LEN cells, one character and one
// DP column entry per cell. Each second-string character and each report
// enter as a token that walks one cell per cycle, so actions 2 and 3 are
// taken one per cycle unless a stall on m_tready holds the chain. Actions 0
// and 1 are taken one per cycle while no token is in the chain and no stall
// holds; after action 2 or 3 they wait for the chain to drain. A stall on
// m_tready freezes the whole chain, and s_tready drops with it. Reset clears
// lengths and overflow, giving an empty pair; no clearing pass.
`default_nettype none

module edit_distance_sub_cost_two #(
    parameter int MAX_LEN = edsc_pkg::MAX_LEN_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] symbol
    input  wire logic [1:0]  s_tuser,   // [1:0] action
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [8:0] distance, [15:9] zero
    output logic [0:0]       m_tuser    // [0] overflow
);

    localparam int IW = $clog2(MAX_LEN);
    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int VW = $clog2(2 * MAX_LEN + 3);
    localparam int SW = (VW > edsc_pkg::DIST_W) ? VW : edsc_pkg::DIST_W;

    logic [LW-1:0]       fl_reg, fl_next;
    logic [LW-1:0]       sl_reg, sl_next;
    logic                ovf_reg, ovf_next;
    logic [LW-1:0]       cnt_reg, cnt_next;
    logic                out_valid_reg;
    logic [edsc_pkg::DIST_W-1:0] out_dist_reg;
    logic                out_ovf_reg;

    edsc_pkg::action_t   act;
    logic [7:0]          sym;
    logic                adv;
    logic                busy;
    logic                take;
    logic                inject;
    logic                retire;
    logic                wr_en;
    logic [SW-1:0]       fin_ext;
    logic [edsc_pkg::DIST_W-1:0] fin_dist;

    edsc_pkg::tok_ctl_t  ctl  [0:MAX_LEN];
    logic [7:0]          tsym [0:MAX_LEN];
    logic [VW-1:0]       newv [0:MAX_LEN];
    logic [VW-1:0]       oldv [0:MAX_LEN];

    assign act  = edsc_pkg::action_t'(s_tuser);
    assign sym  = s_tdata;
    assign adv  = !out_valid_reg || m_tready;
    assign busy = (cnt_reg != '0);

    // fill and restart only touch cells while no token is in flight
    assign s_tready = adv && !(busy && (act == edsc_pkg::ACT_START ||
                                        act == edsc_pkg::ACT_FIRST));
    assign take = s_tvalid && s_tready;

    assign inject = take && ((act == edsc_pkg::ACT_REPORT) ||
                             (act == edsc_pkg::ACT_SECOND && sl_reg < LW'(MAX_LEN)));
    assign wr_en  = take && (act == edsc_pkg::ACT_FIRST) && (sl_reg == '0) &&
                    (fl_reg < LW'(MAX_LEN));
    assign retire = adv && ctl[MAX_LEN].valid;

    // token entering cell 0: left neighbor is the row's column-zero entry
    always_comb
    begin
        ctl[0].valid  = inject;
        ctl[0].report = (act == edsc_pkg::ACT_REPORT);
        ctl[0].ovf    = ovf_reg;
        tsym[0]       = sym;
        oldv[0]       = VW'(sl_reg);
        if (act == edsc_pkg::ACT_REPORT)
        begin
            newv[0] = VW'(sl_reg);
        end
        else
        begin
            newv[0] = VW'(sl_reg) + VW'(1);
        end
    end

    for (genvar g = 0; g < MAX_LEN; g++)
    begin : g_cell
        edsc_cell #(
            .MAX_LEN (MAX_LEN),
            .IDX     (g),
            .IW      (IW),
            .LW      (LW),
            .VW      (VW)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .fl       (fl_reg),
            .wr_en    (wr_en),
            .wr_idx   (fl_reg[IW-1:0]),
            .wr_sym   (sym),
            .in_ctl   (ctl[g]),
            .in_sym   (tsym[g]),
            .in_newv  (newv[g]),
            .in_oldv  (oldv[g]),
            .out_ctl  (ctl[g+1]),
            .out_sym  (tsym[g+1]),
            .out_newv (newv[g+1]),
            .out_oldv (oldv[g+1])
        );
    end

    always_comb
    begin
        fl_next  = fl_reg;
        sl_next  = sl_reg;
        ovf_next = ovf_reg;
        if (take)
        begin
            case (act)
                edsc_pkg::ACT_START:
                begin
                    fl_next  = '0;
                    sl_next  = '0;
                    ovf_next = 1'b0;
                end
                edsc_pkg::ACT_FIRST:
                begin
                    if (sl_reg == '0)
                    begin
                        if (fl_reg < LW'(MAX_LEN))
                        begin
                            fl_next = fl_reg + LW'(1);
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                end
                edsc_pkg::ACT_SECOND:
                begin
                    if (sl_reg < LW'(MAX_LEN))
                    begin
                        sl_next = sl_reg + LW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                default:
                begin
                    fl_next = fl_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (inject && !retire)
        begin
            cnt_next = cnt_reg + LW'(1);
        end
        else if (!inject && retire)
        begin
            cnt_next = cnt_reg - LW'(1);
        end
    end

    assign fin_ext  = SW'(newv[MAX_LEN]);
    assign fin_dist = (fin_ext > SW'(edsc_pkg::DIST_MAX)) ?
                      edsc_pkg::DIST_W'(edsc_pkg::DIST_MAX) :
                      fin_ext[edsc_pkg::DIST_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fl_reg        <= '0;
            sl_reg        <= '0;
            ovf_reg       <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fl_reg  <= fl_next;
            sl_reg  <= sl_next;
            ovf_reg <= ovf_next;
            cnt_reg <= cnt_next;
            if (adv)
            begin
                out_valid_reg <= ctl[MAX_LEN].valid && ctl[MAX_LEN].report;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_dist_reg <= fin_dist;
            out_ovf_reg  <= ctl[MAX_LEN].ovf;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(16 - edsc_pkg::DIST_W){1'b0}}, out_dist_reg};
    assign m_tuser  = out_ovf_reg;

`ifndef ASSERT_OFF
    a_fl_range: assert property (@(posedge clk) disable iff (!rst_n)
        fl_reg <= LW'(MAX_LEN))
        else $error("first length beyond capacity");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= LW'(MAX_LEN))
        else $error("token count beyond chain length");

    a_fill_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (take && (act == edsc_pkg::ACT_START || act == edsc_pkg::ACT_FIRST))
        |-> (cnt_reg == '0))
        else $error("restart or fill taken with tokens in flight");

    a_chain_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |=> (cnt_reg == $past(cnt_reg)))
        else $error("chain moved while output stalled");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import edsc_pkg::*;

    localparam int MAX_LEN    = MAX_LEN_DEF;
    localparam int RAND_ITEMS = 2000;

    typedef struct packed {
        logic              ovf;
        logic [DIST_W-1:0] distance;
    } dist_res_t;

    typedef struct {
        action_t           act;
        logic [SYM_W-1:0]  sym;
        bit                typed;
        logic [DIST_W-1:0] distance;
        logic              ovf;
    } plan_row_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic [1:0]  s_tuser  = ACT_START;
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [15:0] m_tdata;
    logic [0:0]  m_tuser;

    edit_distance_sub_cost_two #(
        .MAX_LEN(MAX_LEN)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always #5 clk = ~clk;

    // shadow copy of the DP engine
    logic [SYM_W-1:0]  fs_chars [MAX_LEN];
    logic [DIST_W-1:0] dp_row   [MAX_LEN+1];
    int                fs_len;
    int                ss_len;
    logic              dropped;

    dist_res_t pending_dist [$];
    int        mismatches = 0;
    int        items_sent = 0;
    int        burst_left = 0;
    int        rx_left    = 0;
    int        rx_mode    = 0;

    // directed rows; typed distances are the obvious ones
    plan_row_t plan [25] = '{
        '{ACT_REPORT, 8'h00, 1'b1, 9'd0, 1'b0},  // nothing loaded after reset
        '{ACT_FIRST,  8'h00, 1'b0, 9'd0, 1'b0},
        '{ACT_FIRST,  8'hFF, 1'b0, 9'd0, 1'b0},
        '{ACT_REPORT, 8'h00, 1'b1, 9'd2, 1'b0},  // first string only
        '{ACT_SECOND, 8'h00, 1'b0, 9'd0, 1'b0},
        '{ACT_SECOND, 8'h80, 1'b0, 9'd0, 1'b0},
        '{ACT_REPORT, 8'hFF, 1'b1, 9'd2, 1'b0},  // one substitution
        '{ACT_FIRST,  8'h55, 1'b0, 9'd0, 1'b0},  // ignored, second already begun
        '{ACT_REPORT, 8'h00, 1'b1, 9'd2, 1'b0},
        '{ACT_SECOND, 8'hFF, 1'b0, 9'd0, 1'b0},
        '{ACT_REPORT, 8'h00, 1'b0, 9'd0, 1'b0},
        '{ACT_START,  8'hAA, 1'b0, 9'd0, 1'b0},
        '{ACT_REPORT, 8'h00, 1'b1, 9'd0, 1'b0},
        '{ACT_SECOND, 8'h7F, 1'b0, 9'd0, 1'b0},
        '{ACT_SECOND, 8'h01, 1'b0, 9'd0, 1'b0},
        '{ACT_REPORT, 8'h00, 1'b1, 9'd2, 1'b0},  // empty first string
        '{ACT_START,  8'h00, 1'b0, 9'd0, 1'b0},
        '{ACT_FIRST,  8'h5A, 1'b0, 9'd0, 1'b0},
        '{ACT_FIRST,  8'hA5, 1'b0, 9'd0, 1'b0},
        '{ACT_FIRST,  8'h3C, 1'b0, 9'd0, 1'b0},
        '{ACT_SECOND, 8'hA5, 1'b0, 9'd0, 1'b0},
        '{ACT_SECOND, 8'h5A, 1'b0, 9'd0, 1'b0},
        '{ACT_SECOND, 8'hC3, 1'b0, 9'd0, 1'b0},
        '{ACT_REPORT, 8'h00, 1'b0, 9'd0, 1'b0},
        '{ACT_START,  8'h00, 1'b0, 9'd0, 1'b0}
    };

    task automatic advance_row(input action_t act, input logic [SYM_W-1:0] sym,
                               output bit yields, output dist_res_t res);
        int diag;
        int above;
        int best;
        int sub;
        yields = 1'b0;
        res    = '0;
        case (act)
            ACT_START:
            begin
                fs_len    = 0;
                ss_len    = 0;
                dropped   = 1'b0;
                dp_row[0] = '0;
            end
            ACT_FIRST:
            begin
                if (ss_len == 0)
                begin
                    if (fs_len >= MAX_LEN)
                        dropped = 1'b1;
                    else
                    begin
                        fs_chars[fs_len]   = sym;
                        dp_row[fs_len + 1] = DIST_W'(fs_len + 1);
                        fs_len++;
                    end
                end
            end
            ACT_SECOND:
            begin
                if (ss_len >= MAX_LEN)
                    dropped = 1'b1;
                else
                begin
                    ss_len++;
                    diag      = int'(dp_row[0]);
                    dp_row[0] = DIST_W'(ss_len);
                    for (int i = 1; i <= fs_len; i++)
                    begin
                        above = int'(dp_row[i]);
                        best  = above + 1;
                        if (int'(dp_row[i-1]) + 1 < best)
                            best = int'(dp_row[i-1]) + 1;
                        sub = (fs_chars[i-1] == sym) ? 0 : SUB_COST;
                        if (diag + sub < best)
                            best = diag + sub;
                        dp_row[i] = DIST_W'(best);
                        diag      = above;
                    end
                end
            end
            default:
            begin
                yields       = 1'b1;
                res.distance = (int'(dp_row[fs_len]) > DIST_MAX) ? DIST_W'(DIST_MAX)
                                                                 : dp_row[fs_len];
                res.ovf      = dropped;
            end
        endcase
    endtask

    // one transaction on the input side, with burst/gap pacing
    task automatic feed(input action_t act, input logic [SYM_W-1:0] sym,
                        input bit typed = 1'b0, input dist_res_t want = '0);
        bit        yields;
        dist_res_t res;
        int        gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 40);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= sym;
        do @(posedge clk); while (!s_tready);
        advance_row(act, sym, yields, res);
        if (yields)
            pending_dist.push_back(typed ? want : res);
        items_sent++;
    endtask

    // mode 0: any byte, 1: four-letter alphabet, 2: disjoint halves per string
    function automatic logic [SYM_W-1:0] pick_sym(input int mode, input bit second);
        case (mode)
            1:       return 8'h40 + 8'($urandom_range(0, 3));
            2:       return second ? 8'($urandom_range(128, 255)) : 8'($urandom_range(0, 127));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic int short_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 8);
    endfunction

    task automatic run_pair(input int flen, input int slen, input int mode,
                            input bit mid_reports);
        feed(ACT_START, pick_sym(0, 1'b0));
        repeat (flen) feed(ACT_FIRST, pick_sym(mode, 1'b0));
        repeat (slen)
        begin
            feed(ACT_SECOND, pick_sym(mode, 1'b1));
            if (mid_reports && $urandom_range(0, 3) == 0)
                feed(ACT_REPORT, pick_sym(0, 1'b0));
        end
        feed(ACT_REPORT, pick_sym(0, 1'b0));
    endtask

    task automatic run_broken();
        int mode;
        mode = $urandom_range(0, 1);
        if ($urandom_range(0, 2) != 0)
            feed(ACT_START, pick_sym(0, 1'b0));
        repeat ($urandom_range(0, 6)) feed(ACT_FIRST, pick_sym(mode, 1'b0));
        repeat ($urandom_range(0, 4)) feed(ACT_SECOND, pick_sym(mode, 1'b1));
        repeat ($urandom_range(0, 3)) feed(ACT_FIRST, pick_sym(mode, 1'b0));
        repeat ($urandom_range(0, 4)) feed(ACT_SECOND, pick_sym(mode, 1'b1));
        feed(ACT_REPORT, pick_sym(0, 1'b0));
    endtask

    task automatic flag_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: mismatch: %s", $realtime, msg);
    endtask

    // output side check, sampled at the rising edge
    always @(posedge clk)
    begin
        dist_res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_dist.size() == 0)
                flag_mismatch($sformatf("result with none pending: tdata=%h tuser=%b",
                                        m_tdata, m_tuser));
            else
            begin
                want = pending_dist.pop_front();
                if (m_tdata !== {7'b0, want.distance})
                    flag_mismatch($sformatf("distance expected %0d got tdata=%h",
                                            want.distance, m_tdata));
                if (m_tuser[0] !== want.ovf)
                    flag_mismatch($sformatf("overflow expected %b got %b",
                                            want.ovf, m_tuser[0]));
            end
        end
    end

    // receiver stalls: stretches of always ready, random and periodic back-pressure
    always @(negedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(10, 150);
        end
        rx_left--;
        case (rx_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 3) != 0);
            2:       m_tready <= (rx_left % 3 != 0);
            default: m_tready <= ($urandom_range(0, 1) == 1);
        endcase
    end

    initial
    begin
        #30_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        dist_res_t want;
        int        pick;
        for (int i = 0; i <= MAX_LEN; i++)
            dp_row[i] = '0;
        for (int i = 0; i < MAX_LEN; i++)
            fs_chars[i] = '0;
        fs_len  = 0;
        ss_len  = 0;
        dropped = 1'b0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            want.distance = plan[i].distance;
            want.ovf      = plan[i].ovf;
            feed(plan[i].act, plan[i].sym, plan[i].typed, want);
        end

        // both strings past MAX_LEN with no common symbol: distance hits 256
        run_pair(MAX_LEN + 2, MAX_LEN + 2, 2, 1'b0);

        while (items_sent < RAND_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
                run_pair(short_len(), short_len(), $urandom_range(0, 1),
                         $urandom_range(0, 1) == 1);
            else if (pick < 80)
                repeat ($urandom_range(1, 10))
                    feed(action_t'($urandom_range(0, 3)), pick_sym(0, 1'b0));
            else if (pick < 97)
                run_broken();
            else
                run_pair($urandom_range(MAX_LEN - 8, MAX_LEN + 4),
                         $urandom_range(MAX_LEN - 8, MAX_LEN + 4),
                         $urandom_range(0, 2), 1'b0);
        end

        @(negedge clk);
        s_tvalid <= 1'b0;

        while (pending_dist.size() != 0)
            @(posedge clk);
        repeat (MAX_LEN + 20) @(posedge clk);

        if (mismatches == 0 && pending_dist.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: edit_distance_sub_cost_two.f
sv/edsc_pkg.sv
sv/edsc_cell.sv
sv/edit_distance_sub_cost_two.sv
tb/sv/testbench.sv
